// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LPA_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that an antecedent implies a consequent sequence.
`define LPA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("implication failed");

`endif

// File: hw/rtl/lpa_pkg.sv
// ----------------------------------------------------------------------------
// lpa_pkg
// Types and constants shared by the line projection pipeline.
// ----------------------------------------------------------------------------
package lpa_pkg;

    localparam int COORD_W = 32;
    localparam int LATENCY = 3 * COORD_W + 11;

    typedef enum logic [1:0] {
        CFG_START_X = 2'd0,
        CFG_START_Y = 2'd1,
        CFG_END_X   = 2'd2,
        CFG_END_Y   = 2'd3
    } lpa_cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] distance;
        logic                      direction;
    } lpa_req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] foot_x;
        logic signed [COORD_W-1:0] foot_y;
        logic signed [COORD_W-1:0] moved_x;
        logic signed [COORD_W-1:0] moved_y;
        logic                      saturated;
    } lpa_rsp_t;

endpackage

// File: hw/rtl/lpa_div.sv
// ----------------------------------------------------------------------------
// lpa_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module lpa_div #(
    parameter int N_W    = 16,
    parameter int D_W    = 8,
    parameter int Q_W    = 8,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [N_W-1:0]    in_num,
    input  logic [D_W-1:0]    in_div,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    out_quo,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg [Q_W];
    logic [Q_W-1:0]    quo_reg   [Q_W];
    logic [SIDE_W-1:0] side_reg  [Q_W];
    logic [D_W-1:0]    rem_reg   [Q_W-1];
    logic [Q_W-1:0]    low_reg   [Q_W-1];
    logic [D_W-1:0]    div_reg   [Q_W-1];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic              valid_prev;
        logic [D_W-1:0]    rem_prev;
        logic [Q_W-1:0]    low_prev;
        logic [Q_W-1:0]    quo_prev;
        logic [D_W-1:0]    div_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [D_W:0]      trial;
        logic              take;
        logic [D_W-1:0]    rem_next;

        if (k == 0) begin : g_first
            assign valid_prev = in_valid;
            assign rem_prev   = D_W'(in_num >> Q_W);
            assign low_prev   = in_num[Q_W-1:0];
            assign quo_prev   = '0;
            assign div_prev   = in_div;
            assign side_prev  = in_side;
        end
        else begin : g_chain
            assign valid_prev = valid_reg[k-1];
            assign rem_prev   = rem_reg[k-1];
            assign low_prev   = low_reg[k-1];
            assign quo_prev   = quo_reg[k-1];
            assign div_prev   = div_reg[k-1];
            assign side_prev  = side_reg[k-1];
        end

        always_comb
        begin
            trial    = {rem_prev, low_prev[Q_W-1]};
            take     = trial >= {1'b0, div_prev};
            rem_next = take ? D_W'(trial - {1'b0, div_prev}) : trial[D_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            quo_reg[k]  <= {quo_prev[Q_W-2:0], take};
            side_reg[k] <= side_prev;
        end

        if (k < Q_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next;
                low_reg[k] <= low_prev << 1;
                div_reg[k] <= div_prev;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_quo   = quo_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

// File: hw/rtl/lpa_sqrt.sv
// ----------------------------------------------------------------------------
// lpa_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module lpa_sqrt #(
    parameter int R_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [2*R_W-1:0] in_rad,
    output logic             out_valid,
    output logic [R_W-1:0]   out_root
);

    localparam int RM_W = R_W + 2;

    logic             valid_reg [R_W];
    logic [R_W-1:0]   root_reg  [R_W];
    logic [RM_W-1:0]  rem_reg   [R_W-1];
    logic [2*R_W-1:0] bits_reg  [R_W-1];

    for (genvar k = 0; k < R_W; k++) begin : g_stage
        logic             valid_prev;
        logic [RM_W-1:0]  rem_prev;
        logic [R_W-1:0]   root_prev;
        logic [2*R_W-1:0] bits_prev;
        logic [RM_W+1:0]  acc;
        logic [RM_W+1:0]  trial;
        logic             take;
        logic [RM_W-1:0]  rem_next;

        if (k == 0) begin : g_first
            assign valid_prev = in_valid;
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign bits_prev  = in_rad;
        end
        else begin : g_chain
            assign valid_prev = valid_reg[k-1];
            assign rem_prev   = rem_reg[k-1];
            assign root_prev  = root_reg[k-1];
            assign bits_prev  = bits_reg[k-1];
        end

        always_comb
        begin
            acc      = {rem_prev, bits_prev[2*R_W-1 -: 2]};
            trial    = (RM_W + 2)'({root_prev, 2'b01});
            take     = acc >= trial;
            rem_next = take ? RM_W'(acc - trial) : acc[RM_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            root_reg[k] <= {root_prev[R_W-2:0], take};
        end

        if (k < R_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k]  <= rem_next;
                bits_reg[k] <= bits_prev << 2;
            end
        end
    end

    assign out_valid = valid_reg[R_W-1];
    assign out_root  = root_reg[R_W-1];

endmodule

// File: hw/rtl/line_project_and_advance.sv
// Throughput: one request per cycle; busy stays low and done is a one-cycle strobe.
// Depth is set by the front stages, the move divider (one quotient bit per stage),
// the root and foot divider stages (one bit per stage each) and output registers.
// Reset clears the line registers to zero and drops every request in flight.
// ----------------------------------------------------------------------------
// line_project_and_advance
// Projects a point onto a configured line and advances the foot along it.
// ----------------------------------------------------------------------------
module line_project_and_advance (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lpa_pkg::lpa_req_t req,
    output logic              done,
    output lpa_pkg::lpa_rsp_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [lpa_pkg::COORD_W-1:0] cfg_data
);
    import lpa_pkg::*;

    localparam int W      = COORD_W;
    localparam int U      = W + 1;
    localparam int HL     = U / 2;
    localparam int HU     = U - HL;
    localparam int DEN_W  = 2 * U;
    localparam int NUM_W  = 2 * U;
    localparam int A_W    = 2 * W;
    localparam int AH     = A_W / 2;
    localparam int S_W    = 4 * W + 1;
    localparam int NF_W   = 3 * W + 3;
    localparam int FQ_W   = W + 2;
    localparam int MQ_W   = 2 * W + 1;
    localparam int RT_W   = W + 2;
    localparam int O_W    = W + 3;
    localparam int SIDE_W = 2 * NF_W + DEN_W + 1;

    localparam logic signed [O_W-1:0] HI = {{(O_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [O_W-1:0] LO = {{(O_W-W+1){1'b1}}, {(W-1){1'b0}}};

    logic signed [W-1:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_START_X: start_x_reg <= cfg_data;
                CFG_START_Y: start_y_reg <= cfg_data;
                CFG_END_X:   end_x_reg   <= cfg_data;
                CFG_END_Y:   end_y_reg   <= cfg_data;
                default:     start_x_reg <= start_x_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // line direction; user must hold it stable while requests are in flight (unchecked)
    logic signed [W:0] dx, dy;
    logic              dx_zero, uyneg_next, uyneg_reg;
    logic [U-1:0]      ux_next, uy_next, ux_reg, uy_reg;

    always_comb
    begin
        dx         = U'(end_x_reg) - U'(start_x_reg);
        dy         = U'(end_y_reg) - U'(start_y_reg);
        dx_zero    = dx == '0;
        ux_next    = dx_zero ? '0 : (dx[W] ? U'(-dx) : U'(dx));
        uy_next    = dx_zero ? U'(1) : (dy[W] ? U'(-dy) : U'(dy));
        uyneg_next = !dx_zero && (dx[W] ? (!dy[W] && dy != '0) : dy[W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ux_reg    <= '0;
            uy_reg    <= U'(1);
            uyneg_reg <= 1'b0;
        end
        else
        begin
            ux_reg    <= ux_next;
            uy_reg    <= uy_next;
            uyneg_reg <= uyneg_next;
        end
    end

    // stage 1: offsets from the end point
    logic signed [W:0] rx, ry;
    logic              v1_reg;
    logic [U-1:0]      s1_rxm_reg, s1_rym_reg;
    logic [W-1:0]      s1_dm_reg;
    logic              s1_rxn_reg, s1_ryn_reg, s1_dneg_reg;

    assign rx = U'(req.point_x) - U'(end_x_reg);
    assign ry = U'(req.point_y) - U'(end_y_reg);

    always_ff @(posedge clk)
    begin
        s1_rxm_reg  <= rx[W] ? U'(-rx) : U'(rx);
        s1_rym_reg  <= ry[W] ? U'(-ry) : U'(ry);
        s1_rxn_reg  <= rx[W];
        s1_ryn_reg  <= ry[W];
        s1_dm_reg   <= req.distance[W-1] ? W'(~req.distance + 1'b1) : W'(req.distance);
        s1_dneg_reg <= req.distance[W-1] ^ req.direction;
    end

    // stage 2: partial products
    logic              v2_reg;
    logic [U+HL-1:0]   s2_pxl_reg, s2_pyl_reg, s2_uxl_reg, s2_uyl_reg;
    logic [U+HU-1:0]   s2_pxh_reg, s2_pyh_reg, s2_uxh_reg, s2_uyh_reg;
    logic [W+HL-1:0]   s2_axl_reg, s2_ayl_reg;
    logic [W+HU-1:0]   s2_axh_reg, s2_ayh_reg;
    logic              s2_rxn_reg, s2_n2_reg, s2_dneg_reg;

    always_ff @(posedge clk)
    begin
        s2_pxl_reg  <= s1_rxm_reg * ux_reg[HL-1:0];
        s2_pxh_reg  <= s1_rxm_reg * ux_reg[U-1:HL];
        s2_pyl_reg  <= s1_rym_reg * uy_reg[HL-1:0];
        s2_pyh_reg  <= s1_rym_reg * uy_reg[U-1:HL];
        s2_uxl_reg  <= ux_reg * ux_reg[HL-1:0];
        s2_uxh_reg  <= ux_reg * ux_reg[U-1:HL];
        s2_uyl_reg  <= uy_reg * uy_reg[HL-1:0];
        s2_uyh_reg  <= uy_reg * uy_reg[U-1:HL];
        s2_axl_reg  <= s1_dm_reg * ux_reg[HL-1:0];
        s2_axh_reg  <= s1_dm_reg * ux_reg[U-1:HL];
        s2_ayl_reg  <= s1_dm_reg * uy_reg[HL-1:0];
        s2_ayh_reg  <= s1_dm_reg * uy_reg[U-1:HL];
        s2_rxn_reg  <= s1_rxn_reg;
        s2_n2_reg   <= s1_ryn_reg ^ uyneg_reg;
        s2_dneg_reg <= s1_dneg_reg;
    end

    // stage 3: sum partials
    logic              v3_reg;
    logic [2*U-1:0]    s3_t1_reg, s3_t2_reg;
    logic [DEN_W-1:0]  s3_den_reg;
    logic [A_W-1:0]    s3_ax_reg, s3_ay_reg;
    logic              s3_rxn_reg, s3_n2_reg, s3_dneg_reg;

    always_ff @(posedge clk)
    begin
        s3_t1_reg   <= (2*U)'(s2_pxl_reg) + ((2*U)'(s2_pxh_reg) << HL);
        s3_t2_reg   <= (2*U)'(s2_pyl_reg) + ((2*U)'(s2_pyh_reg) << HL);
        s3_den_reg  <= DEN_W'(s2_uxl_reg) + (DEN_W'(s2_uxh_reg) << HL)
                     + DEN_W'(s2_uyl_reg) + (DEN_W'(s2_uyh_reg) << HL);
        s3_ax_reg   <= A_W'((W+U)'(s2_axl_reg) + ((W+U)'(s2_axh_reg) << HL));
        s3_ay_reg   <= A_W'((W+U)'(s2_ayl_reg) + ((W+U)'(s2_ayh_reg) << HL));
        s3_rxn_reg  <= s2_rxn_reg;
        s3_n2_reg   <= s2_n2_reg;
        s3_dneg_reg <= s2_dneg_reg;
    end

    // stage 4: signed dot product, squares of the move numerators
    logic              v4_reg;
    logic [NUM_W-1:0]  s4_num_reg;
    logic              s4_numneg_reg, s4_dneg_reg;
    logic [DEN_W-1:0]  s4_den_reg;
    logic [2*AH-1:0]   s4_xll_reg, s4_xlh_reg, s4_xhh_reg;
    logic [2*AH-1:0]   s4_yll_reg, s4_ylh_reg, s4_yhh_reg;
    logic              same_sign, t1_ge;

    assign same_sign = s3_rxn_reg == s3_n2_reg;
    assign t1_ge     = s3_t1_reg >= s3_t2_reg;

    always_ff @(posedge clk)
    begin
        if (same_sign)
        begin
            s4_num_reg <= NUM_W'(s3_t1_reg) + NUM_W'(s3_t2_reg);
        end
        else if (t1_ge)
        begin
            s4_num_reg <= NUM_W'(s3_t1_reg - s3_t2_reg);
        end
        else
        begin
            s4_num_reg <= NUM_W'(s3_t2_reg - s3_t1_reg);
        end
        s4_numneg_reg <= (same_sign || t1_ge) ? s3_rxn_reg : s3_n2_reg;
        s4_dneg_reg   <= s3_dneg_reg;
        s4_den_reg    <= s3_den_reg;
        s4_xll_reg    <= s3_ax_reg[AH-1:0] * s3_ax_reg[AH-1:0];
        s4_xlh_reg    <= s3_ax_reg[AH-1:0] * s3_ax_reg[A_W-1:AH];
        s4_xhh_reg    <= s3_ax_reg[A_W-1:AH] * s3_ax_reg[A_W-1:AH];
        s4_yll_reg    <= s3_ay_reg[AH-1:0] * s3_ay_reg[AH-1:0];
        s4_ylh_reg    <= s3_ay_reg[AH-1:0] * s3_ay_reg[A_W-1:AH];
        s4_yhh_reg    <= s3_ay_reg[A_W-1:AH] * s3_ay_reg[A_W-1:AH];
    end

    // stage 5: foot numerator partials, scaled squares
    logic                v5_reg;
    logic [NUM_W+HL-1:0] s5_nxl_reg, s5_nyl_reg;
    logic [NUM_W+HU-1:0] s5_nxh_reg, s5_nyh_reg;
    logic [S_W-1:0]      s5_sx_reg, s5_sy_reg;
    logic [DEN_W-1:0]    s5_den_reg;
    logic                s5_numneg_reg, s5_dneg_reg;

    always_ff @(posedge clk)
    begin
        s5_nxl_reg    <= s4_num_reg * ux_reg[HL-1:0];
        s5_nxh_reg    <= s4_num_reg * ux_reg[U-1:HL];
        s5_nyl_reg    <= s4_num_reg * uy_reg[HL-1:0];
        s5_nyh_reg    <= s4_num_reg * uy_reg[U-1:HL];
        s5_sx_reg     <= (S_W'(s4_xhh_reg) << (2*AH+2)) + (S_W'(s4_xlh_reg) << (AH+3))
                       + (S_W'(s4_xll_reg) << 2);
        s5_sy_reg     <= (S_W'(s4_yhh_reg) << (2*AH+2)) + (S_W'(s4_ylh_reg) << (AH+3))
                       + (S_W'(s4_yll_reg) << 2);
        s5_den_reg    <= s4_den_reg;
        s5_numneg_reg <= s4_numneg_reg;
        s5_dneg_reg   <= s4_dneg_reg;
    end

    // stage 6: rounded foot numerators
    logic             v6_reg;
    logic [NF_W-1:0]  s6_nfx_reg, s6_nfy_reg;
    logic [S_W-1:0]   s6_sx_reg, s6_sy_reg;
    logic [DEN_W-1:0] s6_den_reg;
    logic             s6_numneg_reg, s6_dneg_reg;

    always_ff @(posedge clk)
    begin
        s6_nfx_reg    <= (NF_W'(s5_nxl_reg) << 1) + (NF_W'(s5_nxh_reg) << (HL+1))
                       + NF_W'(s5_den_reg);
        s6_nfy_reg    <= (NF_W'(s5_nyl_reg) << 1) + (NF_W'(s5_nyh_reg) << (HL+1))
                       + NF_W'(s5_den_reg);
        s6_sx_reg     <= s5_sx_reg;
        s6_sy_reg     <= s5_sy_reg;
        s6_den_reg    <= s5_den_reg;
        s6_numneg_reg <= s5_numneg_reg;
        s6_dneg_reg   <= s5_dneg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // move dividers: floor(4a^2 / den)
    logic              mdx_valid, mdy_valid;
    logic [MQ_W-1:0]   mdx_quo, mdy_quo;
    logic [SIDE_W-1:0] mdx_side;
    logic              mdy_dneg;
    logic [NF_W-1:0]   m_nfx, m_nfy;
    logic [DEN_W-1:0]  m_den;
    logic              m_numneg;

    lpa_div #(.N_W(S_W), .D_W(DEN_W), .Q_W(MQ_W), .SIDE_W(SIDE_W)) u_mdiv_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .in_num    (s6_sx_reg),
        .in_div    (s6_den_reg),
        .in_side   ({s6_nfx_reg, s6_nfy_reg, s6_den_reg, s6_numneg_reg}),
        .out_valid (mdx_valid),
        .out_quo   (mdx_quo),
        .out_side  (mdx_side)
    );

    lpa_div #(.N_W(S_W), .D_W(DEN_W), .Q_W(MQ_W), .SIDE_W(1)) u_mdiv_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .in_num    (s6_sy_reg),
        .in_div    (s6_den_reg),
        .in_side   (s6_dneg_reg),
        .out_valid (mdy_valid),
        .out_quo   (mdy_quo),
        .out_side  (mdy_dneg)
    );

    assign {m_nfx, m_nfy, m_den, m_numneg} = mdx_side;

    // foot dividers and roots run side by side, same depth
    logic              fdx_valid, fdy_valid, rtx_valid, rty_valid;
    logic [FQ_W-1:0]   fdx_quo, fdy_quo;
    logic              f_numneg, f_dneg;
    logic [RT_W-1:0]   rtx_root, rty_root;

    lpa_div #(.N_W(NF_W), .D_W(DEN_W+1), .Q_W(FQ_W), .SIDE_W(1)) u_fdiv_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mdx_valid),
        .in_num    (m_nfx),
        .in_div    ({m_den, 1'b0}),
        .in_side   (m_numneg),
        .out_valid (fdx_valid),
        .out_quo   (fdx_quo),
        .out_side  (f_numneg)
    );

    lpa_div #(.N_W(NF_W), .D_W(DEN_W+1), .Q_W(FQ_W), .SIDE_W(1)) u_fdiv_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mdy_valid),
        .in_num    (m_nfy),
        .in_div    ({m_den, 1'b0}),
        .in_side   (mdy_dneg),
        .out_valid (fdy_valid),
        .out_quo   (fdy_quo),
        .out_side  (f_dneg)
    );

    lpa_sqrt #(.R_W(RT_W)) u_sqrt_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mdx_valid),
        .in_rad    ((2*RT_W)'(mdx_quo)),
        .out_valid (rtx_valid),
        .out_root  (rtx_root)
    );

    lpa_sqrt #(.R_W(RT_W)) u_sqrt_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mdy_valid),
        .in_rad    ((2*RT_W)'(mdy_quo)),
        .out_valid (rty_valid),
        .out_root  (rty_root)
    );

    // final: apply signs, add, clamp
    function automatic logic signed [W-1:0] clamp(input logic signed [O_W-1:0] v);
        logic signed [O_W-1:0] c;
        c = (v > HI) ? HI : ((v < LO) ? LO : v);
        return c[W-1:0];
    endfunction

    logic signed [O_W-1:0] off_fx, off_fy, mv_x, mv_y;
    logic signed [O_W-1:0] fx, fy, mx, my;
    logic [RT_W:0]         mvx_mag, mvy_mag;
    logic                  any_sat, fin_valid;

    always_comb
    begin
        mvx_mag = ((RT_W+1)'(rtx_root) + 1'b1) >> 1;
        mvy_mag = ((RT_W+1)'(rty_root) + 1'b1) >> 1;
        off_fx  = f_numneg ? -$signed(O_W'(fdx_quo)) : $signed(O_W'(fdx_quo));
        off_fy  = (f_numneg ^ uyneg_reg) ? -$signed(O_W'(fdy_quo)) : $signed(O_W'(fdy_quo));
        mv_x    = f_dneg ? -$signed(O_W'(mvx_mag)) : $signed(O_W'(mvx_mag));
        mv_y    = (f_dneg ^ uyneg_reg) ? -$signed(O_W'(mvy_mag)) : $signed(O_W'(mvy_mag));
        fx      = O_W'(end_x_reg) + off_fx;
        fy      = O_W'(end_y_reg) + off_fy;
    end

    assign fin_valid = fdx_valid && fdy_valid && rtx_valid && rty_valid;

    // hold the foot and the move terms before the last add and clamp
    logic                  s7_valid_reg;
    logic signed [O_W-1:0] s7_fx_reg, s7_fy_reg, s7_mvx_reg, s7_mvy_reg;

    always_ff @(posedge clk)
    begin
        s7_fx_reg  <= fx;
        s7_fy_reg  <= fy;
        s7_mvx_reg <= mv_x;
        s7_mvy_reg <= mv_y;
    end

    always_comb
    begin
        mx      = s7_fx_reg + s7_mvx_reg;
        my      = s7_fy_reg + s7_mvy_reg;
        any_sat = s7_fx_reg > HI || s7_fx_reg < LO || s7_fy_reg > HI || s7_fy_reg < LO
               || mx > HI || mx < LO || my > HI || my < LO;
    end

    lpa_rsp_t result_reg, result_next;
    logic     done_reg;

    always_comb
    begin
        result_next.foot_x    = clamp(s7_fx_reg);
        result_next.foot_y    = clamp(s7_fy_reg);
        result_next.moved_x   = clamp(mx);
        result_next.moved_y   = clamp(my);
        result_next.saturated = any_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s7_valid_reg <= fin_valid;
            done_reg     <= s7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: hw/rtl/lpa_chk.sv
// ----------------------------------------------------------------------------
// lpa_chk
// Port-level timing checks for the line projection pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpa_chk (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    import lpa_pkg::*;

    `LPA_ASSERT_IMP(a_start_done, clk, rst_n, start && !busy, ##LATENCY done)
    `LPA_ASSERT_IMP(a_done_start, clk, rst_n, done, $past(start, LATENCY))
    `LPA_ASSERT_IMP(a_back_to_back, clk, rst_n, start && $past(start), ##LATENCY (done && $past(done)))

endmodule

bind line_project_and_advance lpa_chk u_lpa_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
